/* rtl/mk_pkg.sv */
// Shared types, codes and the glyph ROM for the Morse keyer.
// Used by mk_core and morse_keyer_top; depends on nothing.
package mk_pkg;

	// Request modes on the input channel.
	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_TICK  = 2'd1;
	localparam logic [1:0] MODE_ABORT = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_DOT_TICKS  = 3'd0;
	localparam logic [2:0] REG_DASH_TICKS = 3'd1;
	localparam logic [2:0] REG_SYMBOL_GAP = 3'd2;
	localparam logic [2:0] REG_LETTER_GAP = 3'd3;
	localparam logic [2:0] REG_WORD_GAP   = 3'd4;

	// Letter codes: A..Z are below NumLetters, then the word space.
	localparam logic [4:0] NumLetters   = 5'd26;
	localparam logic [4:0] LETTER_SPACE = 5'd26;

	// Timing registers as one bundle.
	typedef struct packed {
		logic [3:0] dot_ticks;
		logic [3:0] dash_ticks;
		logic [3:0] symbol_gap;
		logic [3:0] letter_gap;
		logic [3:0] word_gap;
	} cfg_t;

	// One result.
	typedef struct packed {
		logic led_on;
		logic busy_res;
		logic char_done;
		logic rejected;
	} res_t;

	// Glyph entry: length in [6:4], dash bits in [3:0], first symbol in bit 0.
	function automatic logic [6:0] glyph_lookup(input logic [4:0] ltr);
		logic [6:0] g;
		case (ltr)
			5'd0:    g = 7'h22;
			5'd1:    g = 7'h41;
			5'd2:    g = 7'h45;
			5'd3:    g = 7'h31;
			5'd4:    g = 7'h10;
			5'd5:    g = 7'h44;
			5'd6:    g = 7'h33;
			5'd7:    g = 7'h40;
			5'd8:    g = 7'h20;
			5'd9:    g = 7'h4E;
			5'd10:   g = 7'h35;
			5'd11:   g = 7'h42;
			5'd12:   g = 7'h23;
			5'd13:   g = 7'h21;
			5'd14:   g = 7'h37;
			5'd15:   g = 7'h46;
			5'd16:   g = 7'h4B;
			5'd17:   g = 7'h32;
			5'd18:   g = 7'h30;
			5'd19:   g = 7'h11;
			5'd20:   g = 7'h34;
			5'd21:   g = 7'h48;
			5'd22:   g = 7'h36;
			5'd23:   g = 7'h49;
			5'd24:   g = 7'h4D;
			5'd25:   g = 7'h43;
			default: g = 7'h00;
		endcase
		return g;
	endfunction

endpackage

/* rtl/mk_core.sv */
// Keyer sequencer: phase state, segment counter and the result for each request.
// Depends on mk_pkg for codes, the glyph ROM, cfg_t and res_t.
module mk_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          acc,
	input  logic [1:0]    mode,
	input  logic [4:0]    letter,
	input  mk_pkg::cfg_t  cfg,
	output mk_pkg::res_t  res
);

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_ON   = 3'd1,
		PH_SGAP = 3'd2,
		PH_WORD = 3'd3,
		PH_LGAP = 3'd4
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [3:0] pat_bits_q, pat_bits_d;
	logic [2:0] pat_len_q, pat_len_d;
	logic [2:0] sym_idx_q, sym_idx_d;
	logic [3:0] tick_q, tick_d;
	logic       led_q, led_d;

	logic [6:0] glyph;
	logic [3:0] tick_inc;
	logic [3:0] seg_len;
	logic       seg_end;
	logic [2:0] sym_idx_inc;
	logic       done, rej;

	assign glyph       = mk_pkg::glyph_lookup(letter);
	assign tick_inc    = tick_q + 4'd1;
	assign sym_idx_inc = sym_idx_q + 3'd1;

	// Length of the segment now running; a zero register ends after one tick.
	always_comb begin
		case (phase_q)
			PH_ON:   seg_len = pat_bits_q[sym_idx_q[1:0]] ? cfg.dash_ticks : cfg.dot_ticks;
			PH_SGAP: seg_len = cfg.symbol_gap;
			PH_WORD: seg_len = cfg.word_gap;
			PH_LGAP: seg_len = cfg.letter_gap;
			default: seg_len = 4'd1;
		endcase
	end

	assign seg_end = (tick_inc >= seg_len) || (tick_inc == 4'd0);

	// Next state and flags for the request on the input.
	always_comb begin
		phase_d    = phase_q;
		pat_bits_d = pat_bits_q;
		pat_len_d  = pat_len_q;
		sym_idx_d  = sym_idx_q;
		tick_d     = tick_q;
		led_d      = led_q;
		done       = 1'b0;
		rej        = 1'b0;
		case (mode)
			mk_pkg::MODE_LOAD: begin
				if (phase_q != PH_IDLE) begin
					rej = 1'b1;
				end else if (letter < mk_pkg::NumLetters) begin
					pat_bits_d = glyph[3:0];
					pat_len_d  = glyph[6:4];
					sym_idx_d  = 3'd0;
					tick_d     = 4'd0;
					phase_d    = PH_ON;
				end else if (letter == mk_pkg::LETTER_SPACE) begin
					pat_bits_d = 4'd0;
					pat_len_d  = 3'd0;
					sym_idx_d  = 3'd0;
					tick_d     = 4'd0;
					phase_d    = PH_WORD;
				end
			end
			mk_pkg::MODE_TICK: begin
				led_d  = (phase_q == PH_ON);
				tick_d = seg_end ? 4'd0 : tick_inc;
				case (phase_q)
					PH_ON: begin
						if (seg_end) begin
							phase_d = PH_SGAP;
						end
					end
					PH_SGAP: begin
						if (seg_end) begin
							sym_idx_d = sym_idx_inc;
							phase_d   = (sym_idx_inc >= pat_len_q) ? PH_LGAP : PH_ON;
						end
					end
					PH_WORD: begin
						if (seg_end) begin
							phase_d = PH_LGAP;
						end
					end
					PH_LGAP: begin
						if (seg_end) begin
							done       = 1'b1;
							pat_bits_d = 4'd0;
							pat_len_d  = 3'd0;
							sym_idx_d  = 3'd0;
							phase_d    = PH_IDLE;
						end
					end
					default: begin
						tick_d  = tick_q;
						phase_d = PH_IDLE;
					end
				endcase
			end
			mk_pkg::MODE_ABORT: begin
				pat_bits_d = 4'd0;
				pat_len_d  = 3'd0;
				sym_idx_d  = 3'd0;
				tick_d     = 4'd0;
				phase_d    = PH_IDLE;
				led_d      = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// Result for this request, taken by the output queue when acc is high.
	assign res.led_on    = led_d;
	assign res.busy_res  = (phase_d != PH_IDLE);
	assign res.char_done = done;
	assign res.rejected  = rej;

	// Sequencer state moves only on an accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			pat_bits_q <= 4'd0;
			pat_len_q  <= 3'd0;
			sym_idx_q  <= 3'd0;
			tick_q     <= 4'd0;
			led_q      <= 1'b0;
		end else if (acc) begin
			phase_q    <= phase_d;
			pat_bits_q <= pat_bits_d;
			pat_len_q  <= pat_len_d;
			sym_idx_q  <= sym_idx_d;
			tick_q     <= tick_d;
			led_q      <= led_d;
		end
	end

`ifndef SYNTHESIS
	// The LED is dark whenever no character is in flight.
	a_idle_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> !led_q)
		else $error("LED lit while idle");

	// Keying a symbol needs a loaded pattern.
	a_on_has_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ON) |-> (pat_len_q != 3'd0))
		else $error("symbol phase with empty pattern");

	// A finished character leaves the sequencer idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && res.char_done) |=> (phase_q == PH_IDLE))
		else $error("char_done without return to idle");

	// A rejected load leaves the pattern untouched.
	a_reject_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && res.rejected) |=> ($stable(pat_bits_q) && $stable(pat_len_q)))
		else $error("rejected load changed the pattern");
`endif

endmodule

/* rtl/morse_keyer_top.sv */
// Top level of the Morse keyer: timing registers, sequencer and a two-entry result queue.
// Depends on mk_pkg and mk_core.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------
//  in      | input     | in_valid / in_ready | mode, letter
//  out     | output    | out_valid/out_ready | led_on, busy_res, char_done, rejected
//  cfg     | input     | cfg_we (no wait)    | cfg_addr, cfg_wdata
//
// One request is accepted per cycle while in_ready is high, set by the single
// sequencer state update. Its result is registered in the output or skid entry.
// The output register plus a skid entry let one request in while a result waits;
// in_ready drops only when both entries are full.
// Reset clears the sequencer, the queue and loads the default timings.
module morse_keyer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic [4:0] letter,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       led_on,
	output logic       busy_res,
	output logic       char_done,
	output logic       rejected,
	input  logic       cfg_we,
	input  logic [2:0] cfg_addr,
	input  logic [3:0] cfg_wdata
);

	mk_pkg::cfg_t cfg_q;
	mk_pkg::res_t res;
	mk_pkg::res_t out_q, skid_q;
	logic         out_vld_q, skid_vld_q;
	logic         in_acc, out_acc;

	assign in_ready = !skid_vld_q;
	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_vld_q && out_ready;

	// Timing registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dot_ticks  <= 4'd1;
			cfg_q.dash_ticks <= 4'd3;
			cfg_q.symbol_gap <= 4'd1;
			cfg_q.letter_gap <= 4'd2;
			cfg_q.word_gap   <= 4'd3;
		end else if (cfg_we) begin
			case (cfg_addr)
				mk_pkg::REG_DOT_TICKS:  cfg_q.dot_ticks  <= cfg_wdata;
				mk_pkg::REG_DASH_TICKS: cfg_q.dash_ticks <= cfg_wdata;
				mk_pkg::REG_SYMBOL_GAP: cfg_q.symbol_gap <= cfg_wdata;
				mk_pkg::REG_LETTER_GAP: cfg_q.letter_gap <= cfg_wdata;
				mk_pkg::REG_WORD_GAP:   cfg_q.word_gap   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	mk_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (in_acc),
		.mode   (mode),
		.letter (letter),
		.cfg    (cfg_q),
		.res    (res)
	);

	// Result queue: output register in front, skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (skid_vld_q) begin
				if (out_acc) begin
					skid_vld_q <= 1'b0;
				end
			end else if (out_vld_q) begin
				if (in_acc && !out_acc) begin
					skid_vld_q <= 1'b1;
				end else if (!in_acc && out_acc) begin
					out_vld_q <= 1'b0;
				end
			end else if (in_acc) begin
				out_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_acc) begin
				out_q <= skid_q;
			end
		end else if (in_acc) begin
			if (out_vld_q && !out_acc) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign led_on    = out_q.led_on;
	assign busy_res  = out_q.busy_res;
	assign char_done = out_q.char_done;
	assign rejected  = out_q.rejected;

`ifndef SYNTHESIS
	// The skid entry is only ever filled behind a full output register.
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry valid with empty output register");

	// A request taken with the output full and stalled fills the skid entry.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && out_vld_q && !out_ready) |=> skid_vld_q)
		else $error("request lost behind stalled output");

	// Draining the front with a waiting skid entry keeps a result on the port.
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && out_ready) |=> (out_vld_q && !skid_vld_q))
		else $error("skid entry not moved to output");
`endif

endmodule
